### design/imusb_pkg.sv
// ----------------------------------------------------------------------------
// imusb_pkg
// Shared widths, scale constants, register codes and mounting matrix table
// for the body frame conversion pipeline.
// ----------------------------------------------------------------------------
package imusb_pkg;

  localparam int unsigned N_AXES      = 3;
  localparam int unsigned N_LANES     = 2 * N_AXES;
  localparam int unsigned RAW_W       = 16;
  localparam int unsigned CNT_W       = RAW_W + 1;
  localparam int unsigned COEF_W      = 32;
  localparam int unsigned COEF_BITS   = 30;
  localparam int unsigned MID_BITS    = 16;
  localparam int unsigned SCALE_BITS  = 32;
  localparam int unsigned COEF_SHIFT  = COEF_BITS - MID_BITS;
  localparam int unsigned PROD_W      = COEF_W + CNT_W;
  localparam int unsigned SUM_W       = PROD_W + 2;
  localparam int unsigned V_W         = 33;
  localparam int unsigned K_W         = 24;
  localparam int unsigned SP_W        = V_W + K_W;
  localparam int unsigned SCALED_W    = 40;
  localparam int unsigned RATE_W      = 21;
  localparam int unsigned ACCEL_W     = 23;
  localparam int unsigned BIAS_W      = 18;
  localparam int unsigned MOUNT_ID_W  = 4;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned IN_DATA_W   = N_LANES * RAW_W;
  localparam int unsigned OUT_BITS    = N_AXES * (RATE_W + ACCEL_W);
  localparam int unsigned OUT_DATA_W  = ((OUT_BITS + 7) / 8) * 8;

  localparam int unsigned MOUNT_ENTRIES_DEF = 5;
  localparam int unsigned FRAC_BITS_DEF     = 16;

  localparam logic signed [K_W-1:0] GYRO_K  = 24'sd1144448;
  localparam logic signed [K_W-1:0] ACCEL_K = 24'sd5141509;

  localparam logic signed [COEF_W-1:0] ONE_Q30     = 32'sd1073741824;
  localparam logic [MOUNT_ID_W-1:0]    MEASURED_ID = 4'd2;

  localparam logic signed [COEF_W-1:0] MOUNT_MEAS [N_AXES][N_AXES] = '{
    '{ 32'sd1073722149,  32'sd127374,     -32'sd6498954  },
    '{ 32'sd127374,      32'sd1072917247,  32'sd42072179 },
    '{ 32'sd6498954,    -32'sd42072179,    32'sd1072897572 }
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MOUNT_ID    = 2'd0,
    CFG_GYRO_BIAS_X = 2'd1,
    CFG_GYRO_BIAS_Y = 2'd2,
    CFG_GYRO_BIAS_Z = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic mul;
    logic sum;
    logic rnd;
    logic scl;
    logic fix;
  } lane_en_t;

  function automatic logic signed [COEF_W-1:0] mount_coef(
    input logic [MOUNT_ID_W-1:0] id,
    input logic [1:0]            row,
    input logic [1:0]            col
  );
    if (id == MEASURED_ID) begin
      return MOUNT_MEAS[row][col];
    end
    return (row == col) ? ONE_Q30 : '0;
  endfunction

endpackage

### design/imusb_lane.sv
// ----------------------------------------------------------------------------
// imusb_lane
// One body axis: matrix row dot product, rounding to Q16, unit scaling and
// rounding to the output fraction width.
// ----------------------------------------------------------------------------
module imusb_lane #(
  parameter int unsigned FRAC_BITS = imusb_pkg::FRAC_BITS_DEF,
  parameter logic signed [imusb_pkg::K_W-1:0] SCALE_K = imusb_pkg::GYRO_K
) (
  input  logic                                  clk_i,
  input  imusb_pkg::lane_en_t                   en_i,
  input  logic signed [imusb_pkg::COEF_W-1:0]   coef_i [imusb_pkg::N_AXES],
  input  logic signed [imusb_pkg::CNT_W-1:0]    cnt_i  [imusb_pkg::N_AXES],
  output logic signed [imusb_pkg::SCALED_W-1:0] val_o
);
  import imusb_pkg::*;

  localparam int unsigned SHR = MID_BITS + SCALE_BITS - FRAC_BITS;
  localparam logic [SUM_W:0] HALF1 = (SUM_W + 1)'(1) << (COEF_SHIFT - 1);
  localparam logic [SP_W:0]  HALF2 = (SP_W + 1)'(1) << (SHR - 1);

  logic signed [PROD_W-1:0]   prod_d [N_AXES];
  logic signed [PROD_W-1:0]   prod_q [N_AXES];
  logic signed [SUM_W-1:0]    sum_d, sum_q;
  logic signed [V_W-1:0]      v_d, v_q;
  logic signed [SP_W-1:0]     p_d, p_q;
  logic signed [SCALED_W-1:0] val_d, val_q;

  logic [SUM_W:0] ext1, mag1, rnd1, sh1, t1;
  logic [SP_W:0]  ext2, mag2, rnd2, sh2, t2;
  logic           neg1, neg2;

  // products of one matrix row with the remapped counts
  always_comb begin
    for (int j = 0; j < N_AXES; j++) begin
      prod_d[j] = coef_i[j] * cnt_i[j];
    end
  end

  assign sum_d = SUM_W'(prod_q[0]) + SUM_W'(prod_q[1]) + SUM_W'(prod_q[2]);

  // round Q30 sum to Q16, ties away from zero
  always_comb begin
    neg1 = sum_q[SUM_W-1];
    ext1 = {sum_q[SUM_W-1], sum_q};
    mag1 = neg1 ? (~ext1 + 1'b1) : ext1;
    rnd1 = mag1 + HALF1;
    sh1  = rnd1 >> COEF_SHIFT;
    t1   = neg1 ? (~sh1 + 1'b1) : sh1;
    v_d  = t1[V_W-1:0];
  end

  assign p_d = SP_W'(v_q) * SP_W'(SCALE_K);

  // round scaled product to the output fraction width
  always_comb begin
    neg2  = p_q[SP_W-1];
    ext2  = {p_q[SP_W-1], p_q};
    mag2  = neg2 ? (~ext2 + 1'b1) : ext2;
    rnd2  = mag2 + HALF2;
    sh2   = rnd2 >> SHR;
    t2    = neg2 ? (~sh2 + 1'b1) : sh2;
    val_d = t2[SCALED_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i.mul) begin
      prod_q <= prod_d;
    end
    if (en_i.sum) begin
      sum_q <= sum_d;
    end
    if (en_i.rnd) begin
      v_q <= v_d;
    end
    if (en_i.scl) begin
      p_q <= p_d;
    end
    if (en_i.fix) begin
      val_q <= val_d;
    end
  end

  assign val_o = val_q;

endmodule

### design/imusb_merge.sv
// ----------------------------------------------------------------------------
// imusb_merge
// Gathers the six lane results, removes the gyro bias, saturates each field
// and holds the packed output word.
// ----------------------------------------------------------------------------
module imusb_merge (
  input  logic                                    clk_i,
  input  logic                                    en_i,
  input  logic signed [imusb_pkg::SCALED_W-1:0]   val_i  [imusb_pkg::N_LANES],
  input  logic signed [imusb_pkg::BIAS_W-1:0]     bias_i [imusb_pkg::N_AXES],
  output logic [imusb_pkg::OUT_DATA_W-1:0]        data_o
);
  import imusb_pkg::*;

  wire  [OUT_DATA_W-1:0] data_d;
  logic [OUT_DATA_W-1:0] data_q;

  for (genvar k = 0; k < N_LANES; k++) begin : g_field
    localparam int unsigned W   = (k < N_AXES) ? RATE_W : ACCEL_W;
    localparam int unsigned OFS = (k < N_AXES) ? k * RATE_W
                                               : N_AXES * RATE_W + (k - N_AXES) * ACCEL_W;
    logic signed [SCALED_W:0]  diff;
    logic [SCALED_W-W+1:0]     upper;
    logic                      fits;
    logic [W-1:0]              sat;

    if (k < N_AXES) begin : g_rate
      assign diff = (SCALED_W + 1)'(val_i[k]) - (SCALED_W + 1)'(bias_i[k]);
    end else begin : g_accel
      assign diff = (SCALED_W + 1)'(val_i[k]);
    end

    assign upper = diff[SCALED_W:W-1];
    assign fits  = (&upper) || !(|upper);
    assign sat   = fits ? diff[W-1:0] : {diff[SCALED_W], {(W - 1){~diff[SCALED_W]}}};
    assign data_d[OFS +: W] = sat;
  end

  assign data_d[OUT_DATA_W-1:OUT_BITS] = '0;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign data_o = data_q;

endmodule

### design/imu_sample_to_body_frame.sv
// ----------------------------------------------------------------------------
// imu_sample_to_body_frame
// Six lanes (three gyro, three accel) run in parallel, each with a pipelined
// row product and scaling multiply, followed by the merge output register.
// Throughput: one sample per cycle unless the output stalls.
// Reset clears mount_id, the gyro biases and all pipeline valid flags.
// ----------------------------------------------------------------------------
module imu_sample_to_body_frame #(
  parameter int unsigned MOUNT_ENTRIES = imusb_pkg::MOUNT_ENTRIES_DEF,
  parameter int unsigned FRAC_BITS     = imusb_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // accel_raw_x, accel_raw_y, accel_raw_z, gyro_raw_x, gyro_raw_y, gyro_raw_z
  input  logic [imusb_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // rate_body_x, rate_body_y, rate_body_z, accel_body_x, accel_body_y,
  // accel_body_z, zero fill
  output logic [imusb_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  input  logic                                cfg_we_i,
  input  logic [imusb_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [imusb_pkg::BIAS_W-1:0]        cfg_data_i
);
  import imusb_pkg::*;

  localparam int unsigned NSTAGE = 6;

  logic [MOUNT_ID_W-1:0]      mount_id_q;
  logic [MOUNT_ID_W-1:0]      id_eff;
  logic signed [BIAS_W-1:0]   bias_q [N_AXES];
  logic [NSTAGE-1:0]          valid_q;
  logic [NSTAGE-1:0]          rdy;
  lane_en_t                   lane_en;

  logic signed [RAW_W-1:0]    acc_raw [N_AXES];
  logic signed [RAW_W-1:0]    gyr_raw [N_AXES];
  logic signed [CNT_W-1:0]    acc_b   [N_AXES];
  logic signed [CNT_W-1:0]    gyr_b   [N_AXES];
  logic signed [COEF_W-1:0]   coef    [N_AXES][N_AXES];
  logic signed [SCALED_W-1:0] lane_val [N_LANES];

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mount_id_q <= '0;
      for (int i = 0; i < N_AXES; i++) begin
        bias_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_MOUNT_ID:    mount_id_q <= cfg_data_i[MOUNT_ID_W-1:0];
        CFG_GYRO_BIAS_X: bias_q[0]  <= cfg_data_i;
        CFG_GYRO_BIAS_Y: bias_q[1]  <= cfg_data_i;
        CFG_GYRO_BIAS_Z: bias_q[2]  <= cfg_data_i;
      endcase
    end
  end

  assign id_eff = ({1'b0, mount_id_q} < (MOUNT_ID_W + 1)'(MOUNT_ENTRIES)) ? mount_id_q : '0;

  always_comb begin
    for (int r = 0; r < N_AXES; r++) begin
      for (int c = 0; c < N_AXES; c++) begin
        coef[r][c] = mount_coef(id_eff, 2'(r), 2'(c));
      end
    end
  end

  // unpack and remap sensor axes to body axes
  always_comb begin
    for (int i = 0; i < N_AXES; i++) begin
      acc_raw[i] = s_axis_tdata[i * RAW_W +: RAW_W];
      gyr_raw[i] = s_axis_tdata[(N_AXES + i) * RAW_W +: RAW_W];
    end
    acc_b[0] = CNT_W'(acc_raw[1]);
    acc_b[1] = CNT_W'(0) - CNT_W'(acc_raw[0]);
    acc_b[2] = CNT_W'(acc_raw[2]);
    gyr_b[0] = CNT_W'(gyr_raw[1]);
    gyr_b[1] = CNT_W'(0) - CNT_W'(gyr_raw[0]);
    gyr_b[2] = CNT_W'(gyr_raw[2]);
  end

  // stage handshake, bubbles collapse while the output stalls
  always_comb begin
    rdy[NSTAGE-1] = !valid_q[NSTAGE-1] || m_axis_tready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      rdy[k] = !valid_q[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (rdy[0]) begin
        valid_q[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < NSTAGE; k++) begin
        if (rdy[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  assign lane_en = '{mul: rdy[0], sum: rdy[1], rnd: rdy[2], scl: rdy[3], fix: rdy[4]};

  for (genvar k = 0; k < N_LANES; k++) begin : g_lane
    localparam int unsigned ROW = k % N_AXES;
    if (k < N_AXES) begin : g_gyro
      imusb_lane #(
        .FRAC_BITS (FRAC_BITS),
        .SCALE_K   (GYRO_K)
      ) u_lane (
        .clk_i  (clk_i),
        .en_i   (lane_en),
        .coef_i (coef[ROW]),
        .cnt_i  (gyr_b),
        .val_o  (lane_val[k])
      );
    end else begin : g_accel
      imusb_lane #(
        .FRAC_BITS (FRAC_BITS),
        .SCALE_K   (ACCEL_K)
      ) u_lane (
        .clk_i  (clk_i),
        .en_i   (lane_en),
        .coef_i (coef[ROW]),
        .cnt_i  (acc_b),
        .val_o  (lane_val[k])
      );
    end
  end

  imusb_merge u_merge (
    .clk_i  (clk_i),
    .en_i   (rdy[5]),
    .val_i  (lane_val),
    .bias_i (bias_q),
    .data_o (m_axis_tdata)
  );

  assign s_axis_tready = rdy[0];
  assign m_axis_tvalid = valid_q[NSTAGE-1];

endmodule
